@@ rtl/prba_pkg.sv @@
// Shared constants, register indexes and controller/datapath interface types.
`default_nettype none

package prba_pkg;

   localparam int SLOTS_DEFAULT = 256;

   localparam int NUM_W       = 16;
   localparam int USE_W       = 9;
   localparam int WORD_W      = 32;
   localparam int LANE_W      = $clog2(WORD_W);
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 2;

   localparam logic [CSR_ADDR_W-1:0] REG_RANGE_FIRST = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_RANGE_LAST  = 1'b1;

   localparam logic [NUM_W-1:0] RANGE_FIRST_RST = 16'd0;
   localparam logic [NUM_W-1:0] RANGE_LAST_RST  = 16'd255;

   localparam logic ACT_CLAIM   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   typedef struct packed {
      logic load;
      logic scan;
      logic rel_check;
      logic rel_update;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic found;
      logic exhausted;
      logic out_busy;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/prba_ctrl.sv @@
// Sequencing state machine for claim and release transactions.
`default_nettype none

module prba_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   input  wire logic                    req_tuser,
   output logic                         req_tready,
   input  wire prba_pkg::dp_status_type status,
   output prba_pkg::ctrl_cmd_type       cmd
);

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_CLAIM      = 3'd1;
   localparam logic [2:0] ST_REL_CHECK  = 3'd2;
   localparam logic [2:0] ST_REL_UPDATE = 3'd3;
   localparam logic [2:0] ST_DONE       = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = (req_tuser == prba_pkg::ACT_RELEASE) ? ST_REL_CHECK : ST_CLAIM;
            end
         end
         ST_CLAIM: begin
            cmd.scan = 1'b1;
            if (status.found || status.exhausted) begin
               state_in = ST_DONE;
            end
         end
         ST_REL_CHECK: begin
            cmd.rel_check = 1'b1;
            state_in      = ST_REL_UPDATE;
         end
         ST_REL_UPDATE: begin
            cmd.rel_update = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/prba_dp.sv @@
// Datapath: range registers, taken-map memory with row valid bits, search and result registers.
`default_nettype none

module prba_dp #(
   parameter int SLOTS = prba_pkg::SLOTS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [prba_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [prba_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic [prba_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic                                rsp_tready,
   output logic                                     rsp_tvalid,
   output logic [prba_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   output logic [prba_pkg::RSP_TUSER_W-1:0]         rsp_tuser,
   input  wire prba_pkg::ctrl_cmd_type              cmd,
   output prba_pkg::dp_status_type                  status
);

   localparam int NUM_W  = prba_pkg::NUM_W;
   localparam int WORD_W = prba_pkg::WORD_W;
   localparam int LANE_W = prba_pkg::LANE_W;
   localparam int USE_W  = prba_pkg::USE_W;
   localparam int ROWS   = (SLOTS + WORD_W - 1) / WORD_W;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SPAN_W = $clog2(SLOTS + 1);
   localparam int PAD_W  = prba_pkg::RSP_TDATA_W - USE_W - NUM_W;

   logic [NUM_W-1:0]  first_ff;
   logic [NUM_W-1:0]  last_ff;
   logic [SPAN_W-1:0] span_ff;
   logic [SPAN_W-1:0] span_in;
   logic [NUM_W:0]    span_diff;

   logic [WORD_W-1:0] mem [0:ROWS-1];
   logic [ROWS-1:0]   row_valid_ff;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_vld_ff;
   logic [WORD_W-1:0] rd_eff;

   logic [NUM_W-1:0]  number_ff;
   logic [ROW_W:0]    rd_row_ff;
   logic [ROW_W-1:0]  chk_row_ff;
   logic              chk_valid_ff;
   logic [ROW_W-1:0]  rel_row_ff;
   logic [LANE_W-1:0] rel_lane_ff;
   logic              rel_ok_ff;
   logic [SPAN_W-1:0] use_count_ff;

   logic              granted_ff;
   logic [NUM_W-1:0]  gnum_ff;
   logic              ignored_ff;
   logic              rsp_valid_ff;
   logic              out_granted_ff;
   logic [NUM_W-1:0]  out_number_ff;
   logic              out_ignored_ff;
   logic [USE_W-1:0]  out_use_ff;

   logic              row_more;
   logic              scan_issue;
   logic [NUM_W-1:0]  rel_offset;
   logic              rel_in;
   logic [ROW_W-1:0]  rel_row;
   logic              rd_en;
   logic [ROW_W-1:0]  rd_addr;
   logic [WORD_W-1:0] lane_ok;
   logic [WORD_W-1:0] free_bits;
   logic [LANE_W-1:0] hit_lane;
   logic              hit;
   logic              scan_hit;
   logic              rel_clear;
   logic              wr_en;
   logic [ROW_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;

   // Span of the configured range, clamped to the number of slots.
   always_comb begin
      span_diff = {1'b0, last_ff} - {1'b0, first_ff} + (NUM_W + 1)'(1);
      if (last_ff < first_ff) begin
         span_in = '0;
      end else if (32'(span_diff) > SLOTS) begin
         span_in = SPAN_W'(SLOTS);
      end else begin
         span_in = SPAN_W'(span_diff);
      end
   end

   assign row_more   = 32'({rd_row_ff, {LANE_W{1'b0}}}) < 32'(span_ff);
   assign scan_issue = cmd.scan && row_more;
   assign rel_offset = number_ff - first_ff;
   assign rel_in     = (number_ff >= first_ff) && (32'(rel_offset) < 32'(span_ff));
   assign rel_row    = ROW_W'(rel_offset >> LANE_W);
   assign rd_en      = scan_issue || (cmd.rel_check && rel_in);
   assign rd_addr    = cmd.rel_check ? rel_row : rd_row_ff[ROW_W-1:0];
   assign rd_eff     = rd_vld_ff ? rd_data_ff : '0;

   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         lane_ok[b] = 32'({chk_row_ff, LANE_W'(b)}) < 32'(span_ff);
      end
      free_bits = ~rd_eff & lane_ok;
      hit_lane  = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            hit_lane = LANE_W'(b);
         end
      end
      hit = chk_valid_ff && (|free_bits);
   end

   assign scan_hit  = cmd.scan && hit;
   assign rel_clear = cmd.rel_update && rel_ok_ff && rd_eff[rel_lane_ff];

   always_comb begin
      wr_en   = scan_hit || rel_clear;
      wr_addr = scan_hit ? chk_row_ff : rel_row_ff;
      if (scan_hit) begin
         wr_data = rd_eff | (WORD_W'(1) << hit_lane);
      end else begin
         wr_data = rd_eff & ~(WORD_W'(1) << rel_lane_ff);
      end
   end

   assign status.found     = hit;
   assign status.exhausted = !chk_valid_ff && !row_more;
   assign status.out_busy  = rsp_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= prba_pkg::RANGE_FIRST_RST;
         last_ff  <= prba_pkg::RANGE_LAST_RST;
      end else if (csr_we) begin
         case (csr_addr)
            prba_pkg::REG_RANGE_FIRST: first_ff <= csr_wdata;
            prba_pkg::REG_RANGE_LAST:  last_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff <= '0;
      end else begin
         span_ff <= span_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= row_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         row_valid_ff <= '0;
         use_count_ff <= '0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (scan_hit) begin
            use_count_ff <= use_count_ff + SPAN_W'(1);
         end else if (rel_clear) begin
            use_count_ff <= use_count_ff - SPAN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_row_ff    <= '0;
         chk_row_ff   <= '0;
         chk_valid_ff <= 1'b0;
         rel_ok_ff    <= 1'b0;
      end else if (cmd.load) begin
         rd_row_ff    <= '0;
         chk_valid_ff <= 1'b0;
         rel_ok_ff    <= 1'b0;
      end else begin
         if (cmd.scan) begin
            chk_valid_ff <= scan_issue;
            chk_row_ff   <= rd_row_ff[ROW_W-1:0];
            if (scan_issue) begin
               rd_row_ff <= rd_row_ff + (ROW_W + 1)'(1);
            end
         end
         if (cmd.rel_check) begin
            rel_ok_ff <= rel_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         number_ff  <= req_tdata;
         granted_ff <= 1'b0;
         gnum_ff    <= '0;
         ignored_ff <= 1'b0;
      end else begin
         if (scan_hit) begin
            granted_ff <= 1'b1;
            gnum_ff    <= NUM_W'(32'(first_ff) + 32'({chk_row_ff, hit_lane}));
         end
         if (cmd.rel_check) begin
            ignored_ff  <= !rel_in;
            rel_row_ff  <= rel_row;
            rel_lane_ff <= rel_offset[LANE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_granted_ff <= granted_ff;
         out_number_ff  <= gnum_ff;
         out_ignored_ff <= ignored_ff;
         out_use_ff     <= USE_W'(use_count_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_use_ff, out_number_ff};
   assign rsp_tuser  = {out_ignored_ff, out_granted_ff};

endmodule

`default_nettype wire

@@ rtl/port_range_bitmap_allocator.sv @@
// A release passes through the check and update states; a claim reads the map one 32-slot
// row at a time until a free slot is found or every row of the range has been read, and
// reports no grant when the range is empty. The next transaction is accepted only once
// the result has been loaded, so one transaction is handled at a time.
// A result waiting on rsp_tready holds the next one back. The map has one read port.
// Synchronous active-high reset clears the map and the count and sets the range to 0..255.
`default_nettype none

module port_range_bitmap_allocator #(
   parameter int SLOTS = prba_pkg::SLOTS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [prba_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [prba_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [prba_pkg::REQ_TDATA_W-1:0] req_tdata,  // [15:0] release_number
   input  wire logic                             req_tuser,  // [0] action
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [prba_pkg::RSP_TDATA_W-1:0]      rsp_tdata,  // [15:0] granted_number,
                                                             // [24:16] slots_in_use
   output logic [prba_pkg::RSP_TUSER_W-1:0]      rsp_tuser   // [0] granted,
                                                             // [1] release_ignored
);

   prba_pkg::ctrl_cmd_type  cmd;
   prba_pkg::dp_status_type status;

   prba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   prba_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

@@ rtl/prba_checker.sv @@
// Port-level assertion checker for the allocator and its bind statement.
`default_nettype none

module prba_checker #(
   parameter int SLOTS = prba_pkg::SLOTS_DEFAULT
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [prba_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [prba_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Result transaction changed while stalled.");

   a_grant_not_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("Result is both granted and flagged as an ignored release.");

   a_refused_number_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[prba_pkg::NUM_W-1:0] == '0)
      else $error("Number is nonzero on a result without a grant.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[prba_pkg::NUM_W +: prba_pkg::USE_W]) <= SLOTS)
      else $error("Reported slot count exceeds the number of slots.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

endmodule

bind port_range_bitmap_allocator prba_checker #(.SLOTS(SLOTS)) u_prba_checker (.*);

`default_nettype wire
